// ----- hw/rtl/rfpl_pkg.sv -----
// ----------------------------------------------------------------------------
// rfpl_pkg
// Shared constants and fixed-point helpers of the resonant
// four-pole low-pass filter.
// ----------------------------------------------------------------------------
package rfpl_pkg;

  localparam int CHANNELS_DEF = 8;

  // configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 16;
  localparam logic [CFG_IW-1:0] CFG_CUTOFF       = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_RESONANCE    = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_CUTOFF_SRC   = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_RESONANCE_SRC = 2'd3;

  // datapath widths
  localparam int OPW = 34;         // multiplier operand
  localparam int PW  = 2 * OPW;    // product and wide arithmetic
  localparam int SW  = 32;         // state word, Q4.27
  localparam int MW  = 5 * SW;     // one memory row

  // divider
  localparam int DDW = 61;         // dividend
  localparam int DVW = 34;         // divisor and remainder
  localparam int DQW = 31;         // quotient
  localparam int DIV_STEPS = 31;

  // coefficient constants
  localparam logic [PW-1:0] ONE28   = 68'd268435456;
  localparam logic [32:0]   TP_BASE = 33'd7730954240;  // 117965 * 65536
  localparam logic [32:0]   P_B     = 33'd52429;
  localparam logic [28:0]   T1_C    = 29'd372118383;
  localparam logic [31:0]   T2_BASE = 32'd3221225472;  // 12.0 in Q.28
  localparam logic [30:0]   SIN_A1  = 31'd1686629713;
  localparam logic [30:0]   SIN_A3  = 31'd693598668;
  localparam logic [30:0]   SIN_A5  = 31'd85569310;
  localparam logic [30:0]   SIN_A7  = 31'd5026995;
  localparam logic [30:0]   SIN_A9  = 31'd172269;
  localparam logic [30:0]   SIN_A11 = 31'd3864;

  // division by six: 2^20 = 6 * C6_HI + 4, RECIP6 = ceil(2^26 / 6)
  localparam logic [17:0]   C6_HI   = 18'd174762;
  localparam logic [23:0]   RECIP6  = 24'd11184811;

  // floor(v / 2^s + 1/2)
  function automatic logic signed [PW-1:0] shr_round(input logic signed [PW-1:0] v,
                                                     input int unsigned s);
    logic signed [PW-1:0] half;
    half = PW'(68'sd1 <<< (s - 1));
    return (v + half) >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
    if (v > 68'sd2147483647) return 32'sh7fffffff;
    if (v < -68'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [PW-1:0] v);
    if (v > 68'sd8388607) return 24'sh7fffff;
    if (v < -68'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

endpackage

// ----- hw/rtl/rfpl_if.sv -----
// ----------------------------------------------------------------------------
// rfpl_if
// Valid/ready channels carrying input samples and filtered samples.
// ----------------------------------------------------------------------------
interface rfpl_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         channel;
  logic signed [23:0] sample;
  logic [15:0]        cutoff_sample;
  logic [15:0]        resonance_sample;

  modport source (output valid, channel, sample, cutoff_sample, resonance_sample,
                  input ready);
  modport sink   (input valid, channel, sample, cutoff_sample, resonance_sample,
                  output ready);
endinterface

interface rfpl_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         out_channel;
  logic signed [23:0] out_sample;

  modport source (output valid, out_channel, out_sample, input ready);
  modport sink   (input valid, out_channel, out_sample, output ready);
endinterface

// ----- hw/rtl/rfpl_div.sv -----
// ----------------------------------------------------------------------------
// rfpl_div
// Radix-2 restoring divider, one quotient bit per cycle, for the resonance
// coefficient.
// ----------------------------------------------------------------------------
module rfpl_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rfpl_pkg::DDW-1:0]     dividend,
  input  logic [rfpl_pkg::DVW-1:0]     divisor,
  output logic                         done,
  output logic [rfpl_pkg::DQW-1:0]     quotient
);

  logic                        busy;
  logic [5:0]                  cnt;
  logic [rfpl_pkg::DVW-1:0]    rem;
  logic [rfpl_pkg::DVW-1:0]    dsr;
  logic [rfpl_pkg::DDW-1:0]    work;
  logic [rfpl_pkg::DVW-1:0]    trial;
  logic                        qbit;

  // dividend bits leave at the top of work, quotient bits enter at the bottom
  assign trial    = {rem[rfpl_pkg::DVW-2:0], work[rfpl_pkg::DDW-1]};
  assign qbit     = (trial >= dsr);
  assign quotient = work[rfpl_pkg::DQW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(rfpl_pkg::DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr  <= divisor;
      rem  <= rfpl_pkg::DVW'(dividend[60:31]);
      work <= {dividend[30:0], 30'd0};
    end else if (busy) begin
      rem  <= qbit ? (trial - dsr) : trial;
      work <= {work[rfpl_pkg::DDW-2:0], qbit};
    end
  end

endmodule

// ----- hw/rtl/resonant_four_pole_lowpass_core.sv -----
// ----------------------------------------------------------------------------
// resonant_four_pole_lowpass_core
// Per-channel resonant four-pole ladder low-pass filter in fixed point.
// ----------------------------------------------------------------------------
// One sample is handled at a time, and a new sample is accepted only once
// the previous one has finished, which waits while the output does not keep
// up. The work runs as the state read, 40 steps of a sequencer around one
// shared 34x34 multiplier (coefficients p, k, feedback, four sections, clipper
// with a reciprocal division by six), with a pause within it for the
// bit-serial division that gives the resonance gain, and the load of the
// output register. A result that still waits in the output register holds
// the next one in its final state.
// Filter state lives in one memory row per channel that is read at the start
// and written back at the end; rows never written since reset read as zero
// through per-channel valid bits, so no clearing pass is needed. The output
// register lets the next sample be accepted while a result still waits.
// Samples on channels at or beyond CHANNELS return zero and leave state alone.
module resonant_four_pole_lowpass_core #(
  parameter int CHANNELS = rfpl_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  rfpl_in_if.sink                      din,
  rfpl_out_if.source                   dout,
  input  logic                         cfg_we,
  input  logic [rfpl_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [rfpl_pkg::CFG_DW-1:0]  cfg_data
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW = rfpl_pkg::PW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_RUN  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  // sequencer steps
  localparam logic [5:0] SQ_TP   = 6'd0;
  localparam logic [5:0] SQ_PMUL = 6'd1;
  localparam logic [5:0] SQ_P    = 6'd2;
  localparam logic [5:0] SQ_X2   = 6'd3;
  localparam logic [5:0] SQ_T1   = 6'd4;
  localparam logic [5:0] SQ_H9   = 6'd5;
  localparam logic [5:0] SQ_T2   = 6'd6;
  localparam logic [5:0] SQ_H7   = 6'd7;
  localparam logic [5:0] SQ_M5   = 6'd8;
  localparam logic [5:0] SQ_H5   = 6'd9;
  localparam logic [5:0] SQ_M3   = 6'd10;
  localparam logic [5:0] SQ_H3   = 6'd11;
  localparam logic [5:0] SQ_M1   = 6'd12;
  localparam logic [5:0] SQ_H1   = 6'd13;
  localparam logic [5:0] SQ_SIN  = 6'd14;
  localparam logic [5:0] SQ_K    = 6'd15;
  localparam logic [5:0] SQ_RDIV = 6'd16;
  localparam logic [5:0] SQ_FB   = 6'd17;
  localparam logic [5:0] SQ_X    = 6'd18;
  localparam logic [5:0] SQ_A1   = 6'd19;
  localparam logic [5:0] SQ_B1   = 6'd20;
  localparam logic [5:0] SQ_Y1   = 6'd21;
  localparam logic [5:0] SQ_A2   = 6'd22;
  localparam logic [5:0] SQ_B2   = 6'd23;
  localparam logic [5:0] SQ_Y2   = 6'd24;
  localparam logic [5:0] SQ_A3   = 6'd25;
  localparam logic [5:0] SQ_B3   = 6'd26;
  localparam logic [5:0] SQ_Y3   = 6'd27;
  localparam logic [5:0] SQ_A4   = 6'd28;
  localparam logic [5:0] SQ_B4   = 6'd29;
  localparam logic [5:0] SQ_Y4   = 6'd30;
  localparam logic [5:0] SQ_SQM  = 6'd31;
  localparam logic [5:0] SQ_SQ   = 6'd32;
  localparam logic [5:0] SQ_CUM  = 6'd33;
  localparam logic [5:0] SQ_CMAG = 6'd34;
  localparam logic [5:0] SQ_CHI  = 6'd35;
  localparam logic [5:0] SQ_CLO  = 6'd36;
  localparam logic [5:0] SQ_CQ   = 6'd37;
  localparam logic [5:0] SQ_CLIP = 6'd38;
  localparam logic [5:0] SQ_END  = 6'd39;

  // configuration
  logic [15:0] cutoff_level;
  logic [15:0] resonance_level;
  logic        cutoff_from_stream;
  logic        resonance_from_stream;

  // control
  state_t      state;
  logic [5:0]  step;
  logic        ov;
  logic        skip;
  logic        accept;
  logic        finish;
  logic        in_range;

  // item
  logic [2:0]         ch;
  logic [AW-1:0]      idx;
  logic signed [23:0] smp;
  logic [15:0]        c;
  logic [15:0]        q;

  // coefficients
  logic [32:0]        treg;
  logic [28:0]        preg;
  logic [30:0]        x2;
  logic [28:0]        t1;
  logic [31:0]        t2;
  logic [30:0]        hacc;
  logic [32:0]        num;
  logic [31:0]        den;
  logic signed [29:0] k;
  logic [29:0]        xs;

  // ladder
  logic signed [31:0] xr, y1, y2, y3, y4;
  logic [32:0]        sq;
  logic               cneg;
  logic signed [PW-1:0] acc;
  logic signed [PW-1:0] prod;
  logic signed [rfpl_pkg::OPW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] cube;
  logic signed [PW-1:0] cube_mag;
  logic [39:0]        cmag;
  logic [22:0]        clo;
  logic [37:0]        chi;
  logic [39:0]        qs;

  // state memory: {prev_input, stage_four, stage_three, stage_two, stage_one};
  // the previous stage outputs always equal the stage outputs, so they share
  logic [rfpl_pkg::MW-1:0] mem [CHANNELS];
  logic [rfpl_pkg::MW-1:0] rd;
  logic                    rvld;
  logic [CHANNELS-1:0]     vld;
  logic signed [31:0]      s1, s2, s3, s4, px;

  // divider
  logic                           div_start;
  logic [rfpl_pkg::DDW-1:0]       div_dividend;
  logic [rfpl_pkg::DVW-1:0]       div_divisor;
  logic                           div_done;
  logic [rfpl_pkg::DQW-1:0]       div_quot;

  assign din.ready = (state == S_IDLE);
  assign accept    = din.valid && din.ready;
  assign finish    = (state == S_DONE) && (!ov || dout.ready);
  assign in_range  = (7'(din.channel) < 7'(CHANNELS));
  assign idx       = AW'(7'(ch));
  assign xs        = {c, 14'd0};

  assign s1 = rvld ? rd[31:0]    : '0;
  assign s2 = rvld ? rd[63:32]   : '0;
  assign s3 = rvld ? rd[95:64]   : '0;
  assign s4 = rvld ? rd[127:96]  : '0;
  assign px = rvld ? rd[159:128] : '0;

  assign cube     = rfpl_pkg::shr_round(prod, 23);
  assign cube_mag = cube[PW-1] ? -cube : cube;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff_level          <= 16'hffff;
      resonance_level       <= '0;
      cutoff_from_stream    <= 1'b0;
      resonance_from_stream <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        rfpl_pkg::CFG_CUTOFF:        cutoff_level          <= cfg_data;
        rfpl_pkg::CFG_RESONANCE:     resonance_level       <= cfg_data;
        rfpl_pkg::CFG_CUTOFF_SRC:    cutoff_from_stream    <= cfg_data[0];
        rfpl_pkg::CFG_RESONANCE_SRC: resonance_from_stream <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      ov    <= 1'b0;
      vld   <= '0;
    end else begin
      if (finish) ov <= 1'b1;
      else if (dout.ready) ov <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            step  <= SQ_TP;
            state <= in_range ? S_READ : S_DONE;
          end
        end
        S_READ: state <= S_RUN;
        S_RUN: begin
          step <= step + 6'd1;
          if (step == SQ_RDIV) state <= S_DIV;
          else if (step == SQ_END) state <= S_DONE;
        end
        S_DIV: begin
          if (div_done) state <= S_RUN;
        end
        S_DONE: begin
          if (finish) begin
            state <= S_IDLE;
            if (!skip) vld[idx] <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // state memory, read at the start of an item and written at its end
  always_ff @(posedge clk) begin
    if (finish && !skip) mem[idx] <= {xr, y4, y3, y2, y1};
    if (state == S_READ) begin
      rd   <= mem[idx];
      rvld <= vld[idx];
    end
  end

  // 1 - p in Q.28
  function automatic logic [28:0] ONE28_29();
    return 29'(rfpl_pkg::ONE28) - preg;
  endfunction

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step)
      SQ_PMUL: begin mul_a = 34'(c);           mul_b = 34'(treg); end
      SQ_P:    begin mul_a = 34'(xs);          mul_b = 34'(xs); end
      SQ_X2:   begin mul_a = 34'(ONE28_29());  mul_b = 34'(rfpl_pkg::T1_C); end
      SQ_T1:   begin mul_a = 34'(x2);          mul_b = 34'(rfpl_pkg::SIN_A11); end
      SQ_H9:   begin mul_a = 34'(t1);          mul_b = 34'(t1); end
      SQ_T2, SQ_M5, SQ_M3, SQ_M1: begin
        mul_a = 34'(x2);
        mul_b = 34'(hacc);
      end
      SQ_SIN:  begin mul_a = 34'(xs);          mul_b = 34'(hacc); end
      SQ_K:    begin mul_a = 34'(q);           mul_b = 34'(num); end
      SQ_FB:   begin mul_a = 34'(div_quot);    mul_b = 34'(s4); end
      SQ_A1:   begin mul_a = 34'(preg);        mul_b = 34'(33'(xr) + 33'(px)); end
      SQ_B1:   begin mul_a = 34'(k);           mul_b = 34'(s1); end
      SQ_A2:   begin mul_a = 34'(preg);        mul_b = 34'(33'(y1) + 33'(s1)); end
      SQ_B2:   begin mul_a = 34'(k);           mul_b = 34'(s2); end
      SQ_A3:   begin mul_a = 34'(preg);        mul_b = 34'(33'(y2) + 33'(s2)); end
      SQ_B3:   begin mul_a = 34'(k);           mul_b = 34'(s3); end
      SQ_A4:   begin mul_a = 34'(preg);        mul_b = 34'(33'(y3) + 33'(s3)); end
      SQ_B4:   begin mul_a = 34'(k);           mul_b = 34'(s4); end
      SQ_SQM:  begin mul_a = 34'(y4);          mul_b = 34'(y4); end
      SQ_CUM:  begin mul_a = 34'(sq);          mul_b = 34'(y4); end
      SQ_CHI:  begin mul_a = 34'(cmag[39:20]); mul_b = 34'(rfpl_pkg::C6_HI); end
      SQ_CLO:  begin mul_a = 34'(clo);         mul_b = 34'(rfpl_pkg::RECIP6); end
      default: ;
    endcase
  end

  // resonance gain division
  assign div_start    = (state == S_RUN) && (step == SQ_RDIV);
  assign div_dividend = {prod[48:0], 12'd0};
  assign div_divisor  = rfpl_pkg::DVW'(den);

  rfpl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      ch   <= din.channel;
      smp  <= din.sample;
      c    <= cutoff_from_stream ? din.cutoff_sample : cutoff_level;
      q    <= resonance_from_stream ? din.resonance_sample : resonance_level;
      skip <= !in_range;
    end
    if (state == S_RUN) begin
      prod <= PW'(mul_a) * PW'(mul_b);
      case (step)
        SQ_TP: treg <= rfpl_pkg::TP_BASE - rfpl_pkg::P_B * 33'(c);
        SQ_P: begin
          // p is capped at one
          if (rfpl_pkg::shr_round(prod, 20) > $signed(rfpl_pkg::ONE28))
            preg <= 29'(rfpl_pkg::ONE28);
          else
            preg <= 29'(rfpl_pkg::shr_round(prod, 20));
        end
        SQ_X2: x2   <= 31'(rfpl_pkg::shr_round(prod, 30));
        SQ_T1: t1   <= 29'(rfpl_pkg::shr_round(prod, 28));
        SQ_H9: hacc <= 31'(PW'(rfpl_pkg::SIN_A9) - rfpl_pkg::shr_round(prod, 30));
        SQ_T2: t2   <= rfpl_pkg::T2_BASE + 32'(rfpl_pkg::shr_round(prod, 28));
        SQ_H7: hacc <= 31'(PW'(rfpl_pkg::SIN_A7) - rfpl_pkg::shr_round(prod, 30));
        SQ_H5: hacc <= 31'(PW'(rfpl_pkg::SIN_A5) - rfpl_pkg::shr_round(prod, 30));
        SQ_H3: hacc <= 31'(PW'(rfpl_pkg::SIN_A3) - rfpl_pkg::shr_round(prod, 30));
        SQ_H1: hacc <= 31'(PW'(rfpl_pkg::SIN_A1) - rfpl_pkg::shr_round(prod, 30));
        SQ_SIN: begin
          num <= 33'(t2) + 33'(t1) * 33'd6;
          den <= t2 - 32'(33'(t1) * 33'd6);
        end
        SQ_K: k <= 30'((rfpl_pkg::shr_round(prod, 32) <<< 1) - $signed(rfpl_pkg::ONE28));
        SQ_X: xr <= rfpl_pkg::sat32((PW'(smp) <<< 4) - rfpl_pkg::shr_round(prod, 28));
        SQ_B1, SQ_B2, SQ_B3, SQ_B4: acc <= prod;
        SQ_Y1: y1 <= rfpl_pkg::sat32(rfpl_pkg::shr_round(acc - prod, 28));
        SQ_Y2: y2 <= rfpl_pkg::sat32(rfpl_pkg::shr_round(acc - prod, 28));
        SQ_Y3: y3 <= rfpl_pkg::sat32(rfpl_pkg::shr_round(acc - prod, 28));
        SQ_Y4: y4 <= rfpl_pkg::sat32(rfpl_pkg::shr_round(acc - prod, 28));
        SQ_SQ: sq <= 33'(rfpl_pkg::shr_round(prod, 31));
        SQ_CMAG: begin
          cneg <= cube[PW-1];
          cmag <= cube_mag[39:0];
        end
        // |cube| / 6 split at bit 20: hi * C6_HI + (4 hi + lo) / 6
        SQ_CHI: clo <= {1'b0, cmag[39:20], 2'b00} + 23'(cmag[19:0]);
        SQ_CLO: chi <= prod[37:0];
        SQ_CQ:  qs  <= 40'(chi) + 40'(prod[47:26]);
        // cubic soft clip, cube / 6 truncated toward zero
        SQ_CLIP: y4 <= rfpl_pkg::sat32(PW'(y4) - (cneg ? -$signed(PW'(qs))
                                                       : $signed(PW'(qs))));
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (finish) begin
      dout.out_channel <= ch;
      dout.out_sample  <= skip ? 24'sd0
                               : rfpl_pkg::sat24(rfpl_pkg::shr_round(PW'(y4), 7));
    end
  end

  assign dout.valid = ov;

endmodule
